// File: rtl/core/mot_pkg.sv
package mot_pkg;

   localparam int MOT_MAX_ITEMS = 1024;
   localparam int MOT_VALUE_W = 32;

   // reset value of both candidates
   localparam logic signed [MOT_VALUE_W-1:0] MOT_INT_MIN = {1'b1, {(MOT_VALUE_W-1){1'b0}}};

   typedef enum logic [1:0] {
      RSP_SEL_NONE   = 2'd0,
      RSP_SEL_FIRST  = 2'd1,
      RSP_SEL_SECOND = 2'd2
   } rsp_sel_type;

   typedef struct packed {
      logic        load;        // input word accepted
      logic        scan_start;  // rewind the recount pass
      logic        scan_step;   // issue one buffer read
      logic        rsp_load;    // capture a result word
      rsp_sel_type rsp_sel;
      logic        rsp_end;
      logic        clear;       // back to the empty set
   } mot_cmd_type;

   typedef struct packed {
      logic scan_last;   // read address is at the last stored word
      logic hit_first;
      logic hit_second;  // already excludes an equal first candidate
   } mot_status_type;

endpackage

// File: rtl/core/majority_over_third_finder.sv
// Finds every value that occurs more than floor(n/3) times in a set of n signed
// 32-bit words, the last word marked by req_last. Words load at one per cycle
// into a MAX_ITEMS-deep buffer while a two-candidate vote runs; words past the
// buffer size are dropped and rsp_overflow is set. After the last word the buffer
// is read back once through its single read port to count both candidates, and
// an evaluation step then checks both counts against the set size. One or two
// result words follow (one with rsp_found low if no value qualifies), the final
// one flagged by rsp_end_of_run; no new set is taken until it is consumed.
module majority_over_third_finder import mot_pkg::*; #(
   parameter int MAX_ITEMS = MOT_MAX_ITEMS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [MOT_VALUE_W-1:0] req_value,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [MOT_VALUE_W-1:0] rsp_element,
   output logic                          rsp_found,
   output logic                          rsp_overflow,
   output logic                          rsp_end_of_run
);

   mot_cmd_type    cmd;
   mot_status_type status;

   mot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mot_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_element    (rsp_element),
      .rsp_found      (rsp_found),
      .rsp_overflow   (rsp_overflow),
      .rsp_end_of_run (rsp_end_of_run)
   );

endmodule

// File: rtl/core/mot_ctrl.sv
module mot_ctrl import mot_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  mot_status_type status,
   output mot_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_LOAD       = 6'b000001,
      ST_SCAN       = 6'b000010,
      ST_TAIL       = 6'b000100,
      ST_EVAL       = 6'b001000,
      ST_SEND_FIRST = 6'b010000,
      ST_SEND_LAST  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_accept;

   assign req_stall  = (state_ff != ST_LOAD);
   assign rsp_valid  = (state_ff == ST_SEND_FIRST) || (state_ff == ST_SEND_LAST);
   assign req_accept = req_valid && (state_ff == ST_LOAD);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_sel    = RSP_SEL_NONE;
      cmd.load       = req_accept;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept && req_last) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            // last read word is counted on this edge
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.rsp_load = 1'b1;
            if (status.hit_first) begin
               cmd.rsp_sel = RSP_SEL_FIRST;
               cmd.rsp_end = !status.hit_second;
               state_in    = status.hit_second ? ST_SEND_FIRST : ST_SEND_LAST;
            end else if (status.hit_second) begin
               cmd.rsp_sel = RSP_SEL_SECOND;
               cmd.rsp_end = 1'b1;
               state_in    = ST_SEND_LAST;
            end else begin
               cmd.rsp_sel = RSP_SEL_NONE;
               cmd.rsp_end = 1'b1;
               state_in    = ST_SEND_LAST;
            end
         end
         ST_SEND_FIRST: begin
            if (!rsp_stall) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_SEL_SECOND;
               cmd.rsp_end  = 1'b1;
               state_in     = ST_SEND_LAST;
            end
         end
         ST_SEND_LAST: begin
            if (!rsp_stall) begin
               cmd.clear = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/mot_dp.sv
module mot_dp import mot_pkg::*; #(
   parameter int MAX_ITEMS = MOT_MAX_ITEMS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [MOT_VALUE_W-1:0] req_value,
   input  mot_cmd_type                   cmd,
   output mot_status_type                status,
   output logic signed [MOT_VALUE_W-1:0] rsp_element,
   output logic                          rsp_found,
   output logic                          rsp_overflow,
   output logic                          rsp_end_of_run
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);
   localparam logic [CW-1:0] ONE_CNT = CW'(1);

   logic signed [MOT_VALUE_W-1:0] mem [MAX_ITEMS];

   logic signed [MOT_VALUE_W-1:0] cand1_ff, cand1_in, cand2_ff, cand2_in;
   logic [CW-1:0]                 votes1_ff, votes1_in, votes2_ff, votes2_in;
   logic [CW-1:0]                 total_ff, total_in;
   logic                          dropped_ff, dropped_in;
   logic [CW-1:0]                 scan_ff, scan_in;
   logic [CW-1:0]                 count1_ff, count1_in, count2_ff, count2_in;
   logic                          rd_valid_ff;
   logic signed [MOT_VALUE_W-1:0] rd_data_ff;
   logic signed [MOT_VALUE_W-1:0] elem_ff, elem_in;
   logic                          found_ff, found_in, ovf_ff, ovf_in, end_ff, end_in;
   logic                          store_en;
   logic [CW+1:0]                 triple1, triple2, total_ext;

   assign store_en = cmd.load && (total_ff != MAX_CNT);

   // two-candidate vote
   always_comb begin
      cand1_in   = cand1_ff;
      cand2_in   = cand2_ff;
      votes1_in  = votes1_ff;
      votes2_in  = votes2_ff;
      total_in   = total_ff;
      dropped_in = dropped_ff;
      if (cmd.clear) begin
         cand1_in   = MOT_INT_MIN;
         cand2_in   = MOT_INT_MIN;
         votes1_in  = '0;
         votes2_in  = '0;
         total_in   = '0;
         dropped_in = 1'b0;
      end else if (store_en) begin
         total_in = total_ff + ONE_CNT;
         if (votes1_ff == '0 && cand2_ff != req_value) begin
            cand1_in  = req_value;
            votes1_in = ONE_CNT;
         end else if (votes2_ff == '0 && cand1_ff != req_value) begin
            cand2_in  = req_value;
            votes2_in = ONE_CNT;
         end else if (req_value == cand1_ff) begin
            votes1_in = votes1_ff + ONE_CNT;
         end else if (req_value == cand2_ff) begin
            votes2_in = votes2_ff + ONE_CNT;
         end else begin
            if (votes1_ff != '0) votes1_in = votes1_ff - ONE_CNT;
            if (votes2_ff != '0) votes2_in = votes2_ff - ONE_CNT;
         end
      end else if (cmd.load) begin
         dropped_in = 1'b1;
      end
   end

   // recount pass
   always_comb begin
      scan_in   = scan_ff;
      count1_in = count1_ff;
      count2_in = count2_ff;
      if (cmd.scan_start) begin
         scan_in   = '0;
         count1_in = '0;
         count2_in = '0;
      end else begin
         if (cmd.scan_step) scan_in = scan_ff + ONE_CNT;
         if (rd_valid_ff) begin
            if (rd_data_ff == cand1_ff) count1_in = count1_ff + ONE_CNT;
            if (rd_data_ff == cand2_ff) count2_in = count2_ff + ONE_CNT;
         end
      end
   end

   // count > floor(n/3) is the same as 3*count > n
   assign triple1   = ({2'b00, count1_ff} << 1) + {2'b00, count1_ff};
   assign triple2   = ({2'b00, count2_ff} << 1) + {2'b00, count2_ff};
   assign total_ext = {2'b00, total_ff};

   assign status.scan_last  = (scan_ff == total_ff - ONE_CNT);
   assign status.hit_first  = (triple1 > total_ext);
   assign status.hit_second = (triple2 > total_ext) && (cand2_ff != cand1_ff);

   always_comb begin
      elem_in  = elem_ff;
      found_in = found_ff;
      ovf_in   = ovf_ff;
      end_in   = end_ff;
      if (cmd.rsp_load) begin
         ovf_in = dropped_ff;
         end_in = cmd.rsp_end;
         case (cmd.rsp_sel)
            RSP_SEL_FIRST: begin
               elem_in  = cand1_ff;
               found_in = 1'b1;
            end
            RSP_SEL_SECOND: begin
               elem_in  = cand2_ff;
               found_in = 1'b1;
            end
            default: begin
               elem_in  = '0;
               found_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         mem[total_ff[AW-1:0]] <= req_value;
      end
      rd_data_ff <= mem[scan_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand1_ff    <= MOT_INT_MIN;
         cand2_ff    <= MOT_INT_MIN;
         votes1_ff   <= '0;
         votes2_ff   <= '0;
         total_ff    <= '0;
         dropped_ff  <= 1'b0;
         scan_ff     <= '0;
         count1_ff   <= '0;
         count2_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         cand1_ff    <= cand1_in;
         cand2_ff    <= cand2_in;
         votes1_ff   <= votes1_in;
         votes2_ff   <= votes2_in;
         total_ff    <= total_in;
         dropped_ff  <= dropped_in;
         scan_ff     <= scan_in;
         count1_ff   <= count1_in;
         count2_ff   <= count2_in;
         rd_valid_ff <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff  <= elem_in;
      found_ff <= found_in;
      ovf_ff   <= ovf_in;
      end_ff   <= end_in;
   end

   assign rsp_element    = elem_ff;
   assign rsp_found      = found_ff;
   assign rsp_overflow   = ovf_ff;
   assign rsp_end_of_run = end_ff;

endmodule

// File: rtl/core/mot_checker.sv
module mot_checker import mot_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [MOT_VALUE_W-1:0] rsp_element,
   input logic                          rsp_found,
   input logic                          rsp_overflow,
   input logic                          rsp_end_of_run
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_element) && $stable(rsp_found)
         && $stable(rsp_overflow) && $stable(rsp_end_of_run))
      else $error("stalled result word changed");

   // no input is taken while results of a set are pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while results pending");

   // the last word starts the recount, so input stalls right after it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("input not stalled after last word");

   // an empty result is always the only and final one, with a zero element
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_end_of_run && (rsp_element == '0))
      else $error("malformed empty result");

   // a non-final result is followed at once by a found final one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_end_of_run |=> rsp_valid && rsp_found
         && rsp_end_of_run && ($past(rsp_element) != rsp_element))
      else $error("second result missing or duplicated");

endmodule

bind majority_over_third_finder mot_checker u_mot_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_last       (req_last),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_element    (rsp_element),
   .rsp_found      (rsp_found),
   .rsp_overflow   (rsp_overflow),
   .rsp_end_of_run (rsp_end_of_run)
);

// File: tb/tb_majority_over_third_finder.sv
`timescale 1ns / 1ps

module tb_majority_over_third_finder;
   import mot_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   typedef logic signed [MOT_VALUE_W-1:0] word_type;

   typedef struct {
      word_type element;
      logic     found;
      logic     overflow;
      logic     end_of_run;
   } vote_result_type;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   word_type req_value;
   logic     req_last;
   logic     rsp_valid;
   logic     rsp_stall;
   word_type rsp_element;
   logic     rsp_found;
   logic     rsp_overflow;
   logic     rsp_end_of_run;

   majority_over_third_finder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_element    (rsp_element),
      .rsp_found      (rsp_found),
      .rsp_overflow   (rsp_overflow),
      .rsp_end_of_run (rsp_end_of_run)
   );

   // voting state of the set being loaded
   word_type    lead_value;
   word_type    alt_value;
   logic [10:0] lead_votes;
   logic [10:0] alt_votes;
   logic        words_dropped;
   word_type    stored_words[$];

   vote_result_type pending_results[$];
   word_type        set_words[$];

   int send_idle_pct;
   int rsp_stall_pct;
   int error_count;
   int cycle_count;
   int words_sent;
   int sets_sent;
   int overflow_sets;
   int results_checked;
   int found_results;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   function automatic void clear_votes();
      lead_value = MOT_INT_MIN;
      alt_value = MOT_INT_MIN;
      lead_votes = '0;
      alt_votes = '0;
      words_dropped = 1'b0;
      stored_words.delete();
   endfunction

   function automatic void cast_ballot(input word_type v);
      if (lead_votes == 0 && alt_value != v) begin
         lead_value = v;
         lead_votes = 11'd1;
      end else if (alt_votes == 0 && lead_value != v) begin
         alt_value = v;
         alt_votes = 11'd1;
      end else if (v == lead_value) begin
         lead_votes = lead_votes + 11'd1;
      end else if (v == alt_value) begin
         alt_votes = alt_votes + 11'd1;
      end else begin
         if (lead_votes > 0) lead_votes = lead_votes - 11'd1;
         if (alt_votes > 0) alt_votes = alt_votes - 11'd1;
      end
   endfunction

   // recount both candidates and queue the words the block must report
   function automatic void settle_set();
      int n;
      int lead_count;
      int alt_count;
      int third;
      vote_result_type r;
      vote_result_type found_list[$];
      n = stored_words.size();
      lead_count = 0;
      alt_count = 0;
      foreach (stored_words[i]) begin
         if (stored_words[i] == lead_value) lead_count++;
         if (stored_words[i] == alt_value) alt_count++;
      end
      third = n / 3;
      r.overflow = words_dropped;
      r.end_of_run = 1'b0;
      r.found = 1'b1;
      if (lead_count > third) begin
         r.element = lead_value;
         found_list.insert(found_list.size(), r);
      end
      // equal candidates are reported once
      if (alt_count > third && alt_value != lead_value) begin
         r.element = alt_value;
         found_list.insert(found_list.size(), r);
      end
      found_results += found_list.size();
      if (found_list.size() == 0) begin
         r.element = '0;
         r.found = 1'b0;
         found_list.insert(found_list.size(), r);
      end
      found_list[found_list.size()-1].end_of_run = 1'b1;
      foreach (found_list[i]) pending_results.insert(pending_results.size(), found_list[i]);
      if (words_dropped) overflow_sets++;
      sets_sent++;
      clear_votes();
   endfunction

   function automatic void tally_word(input word_type v, input logic is_last);
      if (stored_words.size() < MOT_MAX_ITEMS) begin
         stored_words.insert(stored_words.size(), v);
         cast_ballot(v);
      end else begin
         words_dropped = 1'b1;
      end
      if (is_last) settle_set();
   endfunction

   function automatic word_type corner_word();
      case ($urandom_range(3))
         0: corner_word = MOT_INT_MIN;
         1: corner_word = ~MOT_INT_MIN;
         2: corner_word = '0;
         default: corner_word = '1;
      endcase
   endfunction

   task automatic send_word(input word_type v, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tally_word(v, is_last);
      words_sent++;
   endtask

   task automatic send_set();
      foreach (set_words[i]) send_word(set_words[i], i == set_words.size() - 1);
      set_words.delete();
   endtask

   // hold the sender off until every result has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // rsp side: stall at random and check each accepted word
   always @(posedge clock) begin
      vote_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word element=%h found=%b", rsp_element,
                                      rsp_found));
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_element !== want.element || rsp_found !== want.found ||
                rsp_overflow !== want.overflow || rsp_end_of_run !== want.end_of_run)
               report_mismatch($sformatf(
                  "expected element=%h found=%b overflow=%b end=%b, got %h %b %b %b",
                  want.element, want.found, want.overflow, want.end_of_run,
                  rsp_element, rsp_found, rsp_overflow, rsp_end_of_run));
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic test_single_word();
      set_words = '{~MOT_INT_MIN};
      send_set();
      set_words = '{word_type'(0)};
      send_set();
      pause_until_drained();
   endtask

   // the most negative value matches the reset candidates, so in a set of it alone both end up equal
   task automatic test_min_value_sets();
      set_words = '{MOT_INT_MIN};
      send_set();
      set_words = '{MOT_INT_MIN, MOT_INT_MIN, word_type'(5)};
      send_set();
      set_words = '{word_type'(-1), MOT_INT_MIN};
      send_set();
      pause_until_drained();
   endtask

   task automatic test_no_majority();
      set_words = '{word_type'(1), word_type'(2), word_type'(3)};
      send_set();
      set_words = '{word_type'(4), word_type'(4), word_type'(1), word_type'(2),
                    word_type'(3), word_type'(5)};
      send_set();
      pause_until_drained();
   endtask

   task automatic test_two_winners();
      set_words = '{word_type'(7), word_type'(-1), word_type'(7), word_type'(-1),
                    ~MOT_INT_MIN};
      send_set();
      set_words = '{~MOT_INT_MIN, MOT_INT_MIN, ~MOT_INT_MIN, MOT_INT_MIN};
      send_set();
      pause_until_drained();
   endtask

   // fills the buffer exactly, then drops the words past it including the last
   task automatic test_buffer_limits();
      word_type b;
      int r;
      b = word_type'($urandom);
      for (int i = 0; i < MOT_MAX_ITEMS + 2; i++) begin
         r = $urandom_range(99);
         set_words.insert(set_words.size(), r < 50 ? b : word_type'($urandom_range(7)));
      end
      send_set();
      pause_until_drained();
   endtask

   task automatic test_random_traffic(input int word_budget);
      int start;
      int len;
      int r;
      int pct_a;
      int pct_b;
      word_type a;
      word_type b;
      start = words_sent;
      while (words_sent - start < word_budget) begin
         r = $urandom_range(99);
         len = r < 80 ? $urandom_range(1, 12) :
               (r < 95 ? $urandom_range(13, 60) : $urandom_range(61, 200));
         a = $urandom_range(4) == 0 ? corner_word() : word_type'($urandom);
         b = $urandom_range(4) == 0 ? corner_word() : word_type'($urandom);
         pct_a = $urandom_range(60);
         pct_b = $urandom_range(40);
         for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < pct_a) set_words.insert(set_words.size(), a);
            else if (r < pct_a + pct_b) set_words.insert(set_words.size(), b);
            else if (r < 90) set_words.insert(set_words.size(), word_type'($urandom));
            else set_words.insert(set_words.size(), word_type'($urandom_range(3)));
         end
         send_set();
      end
      pause_until_drained();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      req_last <= 1'b0;
      rsp_stall <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      error_count = 0;
      words_sent = 0;
      sets_sent = 0;
      overflow_sets = 0;
      results_checked = 0;
      found_results = 0;
      clear_votes();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_word();
      test_min_value_sets();
      test_no_majority();
      test_two_winners();
      send_idle_pct = 16;
      rsp_stall_pct = 16;
      test_buffer_limits();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_traffic(60);
      send_idle_pct = 64;
      test_random_traffic(60);
      send_idle_pct = 0;
      rsp_stall_pct = 64;
      test_random_traffic(60);
      send_idle_pct = 16;
      rsp_stall_pct = 16;
      test_random_traffic(60);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d sets (%0d words, %0d over buffer size), %0d result words",
               sets_sent, words_sent, overflow_sets, results_checked);
      $display("%0d qualifying values reported, %0d mismatches", found_results, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: majority_over_third_finder.f
rtl/core/mot_pkg.sv
rtl/core/mot_ctrl.sv
rtl/core/mot_dp.sv
rtl/core/majority_over_third_finder.sv
rtl/core/mot_checker.sv
tb/tb_majority_over_third_finder.sv
